FILE: src/drhcf_pkg.sv
// Shared types, codes and scaling constants of the dual-range Hall current filter.
package drhcf_pkg;

    // Field and datapath widths.
    localparam int RAW_W     = 12;
    localparam int CUR_W     = 21;
    localparam int LIMIT_W   = 17;
    localparam int THRESH_W  = 20;
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 1;
    localparam int ACC_W     = 26;
    localparam int MAG_W     = 25;
    localparam int MULT_W    = 27;
    localparam int SHIFT_W   = 6;
    localparam int PROD_W    = MAG_W + MULT_W;
    localparam int HR_W      = 21;
    localparam int LR_W      = 18;
    // Sums are sized for a window of up to 32 full-scale samples.
    localparam int HS_W      = 26;
    localparam int LS_W      = 23;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_RANGE_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SC_THRESHOLD    = 1'd1;
    localparam logic [LIMIT_W-1:0]   LIMIT_RESET  = 17'd75000;
    localparam logic [THRESH_W-1:0]  THRESH_RESET = 20'd300000;

    // Reciprocal constants: floor(x / D) == (x * M) >> K for every x below 2**N,
    // with K = N + clog2(D) and M = ceil(2**K / D).
    localparam int K_DIV4095 = 36;
    localparam int K_DIV2706 = 36;
    localparam int K_DIV267  = 34;
    localparam logic [MULT_W-1:0] M_DIV4095 =
        MULT_W'(((64'd1 << K_DIV4095) + 64'd4094) / 64'd4095);
    localparam logic [MULT_W-1:0] M_DIV2706 =
        MULT_W'(((64'd1 << K_DIV2706) + 64'd2705) / 64'd2706);
    localparam logic [MULT_W-1:0] M_DIV267 =
        MULT_W'(((64'd1 << K_DIV267) + 64'd266) / 64'd267);

    // Plain multiplier constants and offsets of the current conversion.
    localparam logic [MULT_W-1:0] M_MV      = 27'd3315;
    localparam logic [MULT_W-1:0] M_HALL    = 27'd3707;
    localparam logic [MULT_W-1:0] M_HCUR    = 27'd250;
    localparam logic [MULT_W-1:0] M_LCUR    = 27'd10000;
    localparam logic signed [ACC_W-1:0] OFS_HCUR = -26'sd2500;
    localparam logic signed [ACC_W-1:0] OFS_LCUR = 26'sd81 - 26'sd2500;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_H_MV,
        ST_H_V,
        ST_H_HP,
        ST_H_HALL,
        ST_H_CUR,
        ST_H_PUSH,
        ST_H_AVG,
        ST_L_MV,
        ST_L_V,
        ST_L_HP,
        ST_L_HALL,
        ST_L_CUR,
        ST_L_QUO,
        ST_L_PUSH,
        ST_L_AVG,
        ST_DONE
    } t_state;

    // Operations of the shared scale unit.
    typedef enum logic [2:0] {
        OP_MUL3315,
        OP_DIV4095,
        OP_MUL3707,
        OP_DIV2706,
        OP_HCUR,
        OP_LCUR,
        OP_DIV267,
        OP_DIVWIN
    } t_op;

    // Operand source of the scale unit.
    typedef enum logic [2:0] {
        SRC_HRAW,
        SRC_LRAW,
        SRC_ACC,
        SRC_HSUM,
        SRC_LSUM
    } t_src;

    // Control word from the sequencer to the datapath.
    typedef struct packed {
        logic busy;
        t_src src;
        t_op  op;
        logic acc_load;
        logic havg_load;
        logic h_push;
        logic l_push;
        logic res_load;
    } t_ctl;

    // Payload of one input transfer.
    typedef struct packed {
        logic [RAW_W-1:0] high_raw;
        logic [RAW_W-1:0] low_raw;
    } t_in;

    // Payload of one output transfer.
    typedef struct packed {
        logic signed [CUR_W-1:0] pack_current_ma;
        logic                    low_range_used;
        logic                    over_current;
    } t_out;

endpackage

FILE: src/drhcf_scale_unit.sv
// Shared signed-magnitude multiply-and-shift unit used for every scaling step.
module drhcf_scale_unit (
    input  drhcf_pkg::t_op                           i_op,
    input  logic signed [drhcf_pkg::ACC_W-1:0]       i_a,
    input  logic [drhcf_pkg::MULT_W-1:0]             i_win_mult,
    input  logic [drhcf_pkg::SHIFT_W-1:0]            i_win_shift,
    output logic signed [drhcf_pkg::ACC_W-1:0]       o_y
);

    logic signed [drhcf_pkg::ACC_W-1:0] addend;
    logic signed [drhcf_pkg::ACC_W-1:0] a_off;
    logic [drhcf_pkg::MULT_W-1:0]       mult;
    logic [drhcf_pkg::SHIFT_W-1:0]      shift;
    logic                               neg_out;
    logic                               a_neg;
    logic [drhcf_pkg::MAG_W-1:0]        mag;
    logic [drhcf_pkg::PROD_W-1:0]       prod;
    logic [drhcf_pkg::PROD_W-1:0]       shifted;
    logic [drhcf_pkg::MAG_W-1:0]        q;
    logic                               sgn;

    // Operation decode: offset, multiplier, right shift and result negation.
    always_comb begin
        addend  = '0;
        mult    = '0;
        shift   = '0;
        neg_out = 1'b0;
        case (i_op)
            drhcf_pkg::OP_MUL3315: begin
                mult = drhcf_pkg::M_MV;
            end
            drhcf_pkg::OP_DIV4095: begin
                mult  = drhcf_pkg::M_DIV4095;
                shift = drhcf_pkg::SHIFT_W'(drhcf_pkg::K_DIV4095);
            end
            drhcf_pkg::OP_MUL3707: begin
                mult = drhcf_pkg::M_HALL;
            end
            drhcf_pkg::OP_DIV2706: begin
                mult  = drhcf_pkg::M_DIV2706;
                shift = drhcf_pkg::SHIFT_W'(drhcf_pkg::K_DIV2706);
            end
            drhcf_pkg::OP_HCUR: begin
                addend = drhcf_pkg::OFS_HCUR;
                mult   = drhcf_pkg::M_HCUR;
            end
            drhcf_pkg::OP_LCUR: begin
                addend = drhcf_pkg::OFS_LCUR;
                mult   = drhcf_pkg::M_LCUR;
            end
            drhcf_pkg::OP_DIV267: begin
                mult  = drhcf_pkg::M_DIV267;
                shift = drhcf_pkg::SHIFT_W'(drhcf_pkg::K_DIV267);
            end
            drhcf_pkg::OP_DIVWIN: begin
                mult    = i_win_mult;
                shift   = i_win_shift;
                neg_out = 1'b1;
            end
            default: begin
                mult = '0;
            end
        endcase
    end

    // Work on the magnitude so that every quotient truncates toward zero.
    always_comb begin
        a_off   = i_a + addend;
        a_neg   = a_off[drhcf_pkg::ACC_W-1];
        mag     = a_neg ? drhcf_pkg::MAG_W'(-a_off) : drhcf_pkg::MAG_W'(a_off);
        prod    = drhcf_pkg::PROD_W'(mag) * drhcf_pkg::PROD_W'(mult);
        shifted = prod >> shift;
        q       = shifted[drhcf_pkg::MAG_W-1:0];
        sgn     = a_neg ^ neg_out;
        o_y     = sgn ? -$signed({1'b0, q}) : $signed({1'b0, q});
    end

endmodule

FILE: src/drhcf_window.sv
// Sample rings and running sums of the two moving averages.
module drhcf_window #(
    parameter int WINDOW_LEN = 10
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_push_high,
    input  logic                                  i_push_low,
    input  logic signed [drhcf_pkg::ACC_W-1:0]    i_sample,
    output logic signed [drhcf_pkg::HS_W-1:0]     o_high_sum,
    output logic signed [drhcf_pkg::LS_W-1:0]     o_low_sum
);

    localparam int PW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

    logic signed [drhcf_pkg::HR_W-1:0] r_high_ring [WINDOW_LEN];
    logic signed [drhcf_pkg::LR_W-1:0] r_low_ring  [WINDOW_LEN];
    logic signed [drhcf_pkg::HS_W-1:0] r_high_sum;
    logic signed [drhcf_pkg::HS_W-1:0] n_high_sum;
    logic signed [drhcf_pkg::LS_W-1:0] r_low_sum;
    logic signed [drhcf_pkg::LS_W-1:0] n_low_sum;
    logic [PW-1:0]                     r_pos;
    logic [PW-1:0]                     n_pos;
    logic signed [drhcf_pkg::HR_W-1:0] high_sample;
    logic signed [drhcf_pkg::LR_W-1:0] low_sample;

    // Replace the oldest entry in the sum and advance the shared position.
    always_comb begin
        high_sample = i_sample[drhcf_pkg::HR_W-1:0];
        low_sample  = i_sample[drhcf_pkg::LR_W-1:0];
        n_high_sum  = r_high_sum - drhcf_pkg::HS_W'(r_high_ring[r_pos])
                      + drhcf_pkg::HS_W'(high_sample);
        n_low_sum   = r_low_sum - drhcf_pkg::LS_W'(r_low_ring[r_pos])
                      + drhcf_pkg::LS_W'(low_sample);
        n_pos       = (r_pos == PW'(WINDOW_LEN - 1)) ? '0 : r_pos + 1'b1;
    end

    // Both channels are pushed once per item; the low push ends the item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW_LEN; i++) begin
                r_high_ring[i] <= '0;
                r_low_ring[i]  <= '0;
            end
            r_high_sum <= '0;
            r_low_sum  <= '0;
            r_pos      <= '0;
        end else begin
            if (i_push_high) begin
                r_high_ring[r_pos] <= high_sample;
                r_high_sum         <= n_high_sum;
            end
            if (i_push_low) begin
                r_low_ring[r_pos] <= low_sample;
                r_low_sum         <= n_low_sum;
                r_pos             <= n_pos;
            end
        end
    end

    assign o_high_sum = r_high_sum;
    assign o_low_sum  = r_low_sum;

endmodule

FILE: src/drhcf_ctrl.sv
// Step sequencer that drives the shared scale unit through one item.
module drhcf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_free,
    output drhcf_pkg::t_ctl o_ctl
);

    drhcf_pkg::t_state r_state;
    drhcf_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= drhcf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and control word for each step.
    always_comb begin
        n_state         = r_state;
        o_ctl           = '0;
        o_ctl.busy      = (r_state != drhcf_pkg::ST_IDLE);
        o_ctl.src       = drhcf_pkg::SRC_ACC;
        o_ctl.op        = drhcf_pkg::OP_MUL3315;
        case (r_state)
            drhcf_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = drhcf_pkg::ST_H_MV;
                end
            end
            drhcf_pkg::ST_H_MV: begin
                o_ctl.src      = drhcf_pkg::SRC_HRAW;
                o_ctl.acc_load = 1'b1;
                n_state        = drhcf_pkg::ST_H_V;
            end
            drhcf_pkg::ST_H_V: begin
                o_ctl.op       = drhcf_pkg::OP_DIV4095;
                o_ctl.acc_load = 1'b1;
                n_state        = drhcf_pkg::ST_H_HP;
            end
            drhcf_pkg::ST_H_HP: begin
                o_ctl.op       = drhcf_pkg::OP_MUL3707;
                o_ctl.acc_load = 1'b1;
                n_state        = drhcf_pkg::ST_H_HALL;
            end
            drhcf_pkg::ST_H_HALL: begin
                o_ctl.op       = drhcf_pkg::OP_DIV2706;
                o_ctl.acc_load = 1'b1;
                n_state        = drhcf_pkg::ST_H_CUR;
            end
            drhcf_pkg::ST_H_CUR: begin
                o_ctl.op       = drhcf_pkg::OP_HCUR;
                o_ctl.acc_load = 1'b1;
                n_state        = drhcf_pkg::ST_H_PUSH;
            end
            drhcf_pkg::ST_H_PUSH: begin
                o_ctl.h_push = 1'b1;
                n_state      = drhcf_pkg::ST_H_AVG;
            end
            drhcf_pkg::ST_H_AVG: begin
                o_ctl.src       = drhcf_pkg::SRC_HSUM;
                o_ctl.op        = drhcf_pkg::OP_DIVWIN;
                o_ctl.havg_load = 1'b1;
                n_state         = drhcf_pkg::ST_L_MV;
            end
            drhcf_pkg::ST_L_MV: begin
                o_ctl.src      = drhcf_pkg::SRC_LRAW;
                o_ctl.acc_load = 1'b1;
                n_state        = drhcf_pkg::ST_L_V;
            end
            drhcf_pkg::ST_L_V: begin
                o_ctl.op       = drhcf_pkg::OP_DIV4095;
                o_ctl.acc_load = 1'b1;
                n_state        = drhcf_pkg::ST_L_HP;
            end
            drhcf_pkg::ST_L_HP: begin
                o_ctl.op       = drhcf_pkg::OP_MUL3707;
                o_ctl.acc_load = 1'b1;
                n_state        = drhcf_pkg::ST_L_HALL;
            end
            drhcf_pkg::ST_L_HALL: begin
                o_ctl.op       = drhcf_pkg::OP_DIV2706;
                o_ctl.acc_load = 1'b1;
                n_state        = drhcf_pkg::ST_L_CUR;
            end
            drhcf_pkg::ST_L_CUR: begin
                o_ctl.op       = drhcf_pkg::OP_LCUR;
                o_ctl.acc_load = 1'b1;
                n_state        = drhcf_pkg::ST_L_QUO;
            end
            drhcf_pkg::ST_L_QUO: begin
                o_ctl.op       = drhcf_pkg::OP_DIV267;
                o_ctl.acc_load = 1'b1;
                n_state        = drhcf_pkg::ST_L_PUSH;
            end
            drhcf_pkg::ST_L_PUSH: begin
                o_ctl.l_push = 1'b1;
                n_state      = drhcf_pkg::ST_L_AVG;
            end
            drhcf_pkg::ST_L_AVG: begin
                o_ctl.src      = drhcf_pkg::SRC_LSUM;
                o_ctl.op       = drhcf_pkg::OP_DIVWIN;
                o_ctl.acc_load = 1'b1;
                n_state        = drhcf_pkg::ST_DONE;
            end
            drhcf_pkg::ST_DONE: begin
                // Wait here only while the previous result is still unclaimed.
                if (i_out_free) begin
                    o_ctl.res_load = 1'b1;
                    n_state        = drhcf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = drhcf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/dual_range_hall_current_filter.sv
// Top level of the dual-range Hall current filter.
//
// Each input transfer carries one pair of 12-bit ADC codes, high-range and
// low-range sensor. Both are scaled to milliamps, averaged over WINDOW_LEN
// samples each, negated, and the low-range value is chosen while its magnitude
// stays under low_range_limit; over_current is set when the chosen current is
// above short_circuit_threshold. All scaling and both divisions by the window
// length run one after another through a single multiply-and-shift unit under
// a step sequencer, so an item occupies the block from its input transfer
// until its result is loaded, and no new item is taken before then. The input
// side stalls for that whole time and accepts again while a result still waits
// in the output register; the sequencer only holds at its last step when that
// register is still full. The rings and sums are cleared by reset and need no
// clearing pass. Configuration writes take effect at once and belong between
// items.
module dual_range_hall_current_filter #(
    parameter int WINDOW_LEN = 10
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  drhcf_pkg::t_in                       i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output drhcf_pkg::t_out                      o_out_data,
    input  logic                                 i_cfg_we,
    input  logic [drhcf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [drhcf_pkg::CFG_W-1:0]          i_cfg_data
);

    // Reciprocal of the window length for the shared unit.
    localparam int WIN_SHIFT = drhcf_pkg::MAG_W + $clog2(WINDOW_LEN);
    localparam logic [drhcf_pkg::MULT_W-1:0] WIN_MULT = drhcf_pkg::MULT_W'(
        ((64'd1 << WIN_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

    drhcf_pkg::t_ctl                    ctl;
    logic                               out_free;
    logic                               in_fire;
    logic signed [drhcf_pkg::ACC_W-1:0] unit_a;
    logic signed [drhcf_pkg::ACC_W-1:0] unit_y;
    logic signed [drhcf_pkg::HS_W-1:0]  high_sum;
    logic signed [drhcf_pkg::LS_W-1:0]  low_sum;
    logic signed [drhcf_pkg::ACC_W-1:0] lim;
    logic signed [drhcf_pkg::ACC_W-1:0] thresh;
    logic                               use_low;
    logic signed [drhcf_pkg::ACC_W-1:0] sel;

    logic [drhcf_pkg::RAW_W-1:0]        r_high_raw;
    logic [drhcf_pkg::RAW_W-1:0]        r_low_raw;
    logic signed [drhcf_pkg::ACC_W-1:0] r_acc;
    logic signed [drhcf_pkg::ACC_W-1:0] r_havg;
    logic [drhcf_pkg::LIMIT_W-1:0]      r_low_range_limit;
    logic [drhcf_pkg::THRESH_W-1:0]     r_sc_threshold;
    logic                               r_out_valid;
    drhcf_pkg::t_out                    r_out_data;

    assign in_fire    = i_in_valid && !ctl.busy;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = ctl.busy;

    // Step sequencer.
    drhcf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (out_free),
        .o_ctl      (ctl)
    );

    // Operand selection for the shared unit.
    always_comb begin
        case (ctl.src)
            drhcf_pkg::SRC_HRAW: unit_a = drhcf_pkg::ACC_W'(r_high_raw);
            drhcf_pkg::SRC_LRAW: unit_a = drhcf_pkg::ACC_W'(r_low_raw);
            drhcf_pkg::SRC_HSUM: unit_a = drhcf_pkg::ACC_W'(high_sum);
            drhcf_pkg::SRC_LSUM: unit_a = drhcf_pkg::ACC_W'(low_sum);
            default:             unit_a = r_acc;
        endcase
    end

    drhcf_scale_unit u_scale (
        .i_op        (ctl.op),
        .i_a         (unit_a),
        .i_win_mult  (WIN_MULT),
        .i_win_shift (drhcf_pkg::SHIFT_W'(WIN_SHIFT)),
        .o_y         (unit_y)
    );

    drhcf_window #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_high (ctl.h_push),
        .i_push_low  (ctl.l_push),
        .i_sample    (r_acc),
        .o_high_sum  (high_sum),
        .o_low_sum   (low_sum)
    );

    // Input capture and working registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_high_raw <= i_in_data.high_raw;
            r_low_raw  <= i_in_data.low_raw;
        end
        if (ctl.acc_load) begin
            r_acc <= unit_y;
        end
        if (ctl.havg_load) begin
            r_havg <= unit_y;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_range_limit <= drhcf_pkg::LIMIT_RESET;
            r_sc_threshold    <= drhcf_pkg::THRESH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                drhcf_pkg::CFG_LOW_RANGE_LIMIT: begin
                    r_low_range_limit <= i_cfg_data[drhcf_pkg::LIMIT_W-1:0];
                end
                drhcf_pkg::CFG_SC_THRESHOLD: begin
                    r_sc_threshold <= i_cfg_data[drhcf_pkg::THRESH_W-1:0];
                end
                default: begin
                    r_sc_threshold <= r_sc_threshold;
                end
            endcase
        end
    end

    // Range selection and over-current compare; the low average sits in r_acc.
    always_comb begin
        lim     = $signed(drhcf_pkg::ACC_W'(r_low_range_limit));
        thresh  = $signed(drhcf_pkg::ACC_W'(r_sc_threshold));
        use_low = (r_acc < lim) && (r_acc > -lim);
        sel     = use_low ? r_acc : r_havg;
    end

    // Output register: holds a result until its transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.res_load) begin
            r_out_data.pack_current_ma <= sel[drhcf_pkg::CUR_W-1:0];
            r_out_data.low_range_used  <= use_low;
            r_out_data.over_current    <= (sel > thresh);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
